// ----- src/integer_hypot_newton_core_macros.svh -----
// assertion macros for the integer hypot newton core
// relies on clk and arst_n being visible at the point of use
`ifndef INTEGER_HYPOT_NEWTON_CORE_MACROS_SVH
`define INTEGER_HYPOT_NEWTON_CORE_MACROS_SVH

// antecedent and consequent in the same cycle
`define IHN_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the cycle after the antecedent
`define IHN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/ihn_pkg.sv -----
// shared types and constants for the integer hypot newton core
// no dependencies
`default_nettype none

package ihn_pkg;

	localparam int COORD_WIDTH_DEF = 10;
	localparam int MAX_ITER_DEF    = 8;
	localparam int DIST_WIDTH      = 11;
	localparam int DIST_MAX        = 2047;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SQ_DX,
		ST_SQ_SUM,
		ST_CHECK,
		ST_DIV_WAIT,
		ST_MUL_D,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		MUL_DY,
		MUL_DX,
		MUL_D
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     init;
		logic     tgt_copy;
		logic     tgt_add;
		logic     prod_en;
		mul_sel_t mul_sel;
		logic     div_start;
		logic     step;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic axis;
		logic div_done;
		logic quo_zero;
		logic iter_max;
	} sts_t;

endpackage

`default_nettype wire

// ----- src/ihn_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// standalone, no package dependencies
`default_nettype none

module ihn_div #(
	parameter int NUM_W = 22,
	parameter int DEN_W = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quo
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CW'(1);
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	// quotient bits shift into the numerator register as it empties
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

`default_nettype wire

// ----- src/ihn_dp.sv -----
// datapath: differences, shared squaring multiplier, estimate and target registers
// uses ihn_pkg command/status types and ihn_div
`default_nettype none

module ihn_dp #(
	parameter int COORD_WIDTH = ihn_pkg::COORD_WIDTH_DEF,
	parameter int MAX_ITER    = ihn_pkg::MAX_ITER_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ihn_pkg::cmd_t          cmd,
	output ihn_pkg::sts_t               sts,
	input  wire logic [COORD_WIDTH-1:0] first_row,
	input  wire logic [COORD_WIDTH-1:0] first_col,
	input  wire logic [COORD_WIDTH-1:0] second_row,
	input  wire logic [COORD_WIDTH-1:0] second_col,
	output logic [ihn_pkg::DIST_WIDTH-1:0] dist_value
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;
	localparam int IW = $clog2(MAX_ITER + 1);
	localparam int SW = (DW > ihn_pkg::DIST_WIDTH) ? DW : ihn_pkg::DIST_WIDTH;

	logic [COORD_WIDTH-1:0] row_diff;
	logic [COORD_WIDTH-1:0] col_diff;
	logic [COORD_WIDTH-1:0] dy_q;
	logic [COORD_WIDTH-1:0] dx_q;
	logic [COORD_WIDTH-1:0] big;
	logic [COORD_WIDTH-1:0] little;
	logic [DW-1:0]          d_init;
	logic [DW-1:0]          d_q;
	logic [DW-1:0]          mul_a;
	logic [PW-1:0]          product;
	logic [PW-1:0]          prod_q;
	logic [PW-1:0]          tgt_q;
	logic [PW-1:0]          div_num;
	logic [DW:0]            div_den;
	logic [PW-1:0]          quo;
	logic                   div_done;
	logic [IW-1:0]          iter_q;
	logic [SW-1:0]          d_ext;
	logic [ihn_pkg::DIST_WIDTH-1:0] dist_sat;
	logic [ihn_pkg::DIST_WIDTH-1:0] dist_q;

	assign row_diff = (first_row > second_row) ? (first_row - second_row)
	                                           : (second_row - first_row);
	assign col_diff = (first_col > second_col) ? (first_col - second_col)
	                                           : (second_col - first_col);

	assign big    = (dy_q >= dx_q) ? dy_q : dx_q;
	assign little = (dy_q >= dx_q) ? dx_q : dy_q;
	assign d_init = DW'(big) + DW'(little >> 1);

	always_comb begin
		unique case (cmd.mul_sel)
			ihn_pkg::MUL_DY: mul_a = DW'(dy_q);
			ihn_pkg::MUL_DX: mul_a = DW'(dx_q);
			ihn_pkg::MUL_D:  mul_a = d_q;
			default:         mul_a = d_q;
		endcase
	end

	assign product = PW'(mul_a) * PW'(mul_a);

	// once above the root the estimate stays there; a start just below it
	// (odd min) is off by less than 2*d, so its correction is zero
	assign div_num = (prod_q > tgt_q) ? (prod_q - tgt_q) : '0;
	assign div_den = {d_q, 1'b0};

	ihn_div #(
		.NUM_W(PW),
		.DEN_W(DW + 1)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (quo)
	);

	assign d_ext    = SW'(d_q);
	assign dist_sat = (d_ext > SW'(ihn_pkg::DIST_MAX)) ?
	                  ihn_pkg::DIST_WIDTH'(ihn_pkg::DIST_MAX) :
	                  d_ext[ihn_pkg::DIST_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.init) begin
			iter_q <= '0;
		end else if (cmd.step) begin
			iter_q <= iter_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dy_q <= row_diff;
			dx_q <= col_diff;
		end
		if (cmd.init) begin
			d_q <= d_init;
		end else if (cmd.step) begin
			d_q <= d_q - quo[DW-1:0];
		end
		if (cmd.prod_en) begin
			prod_q <= product;
		end
		if (cmd.tgt_copy) begin
			tgt_q <= prod_q;
		end else if (cmd.tgt_add) begin
			tgt_q <= tgt_q + prod_q;
		end
		if (cmd.emit) begin
			dist_q <= dist_sat;
		end
	end

	assign sts.axis     = (dy_q == '0) || (dx_q == '0);
	assign sts.div_done = div_done;
	assign sts.quo_zero = (quo == '0);
	assign sts.iter_max = (iter_q == IW'(MAX_ITER));

	assign dist_value = dist_q;

endmodule

`default_nettype wire

// ----- src/ihn_ctrl.sv -----
// controller state machine sequencing the squaring, division and correction steps
// uses ihn_pkg state, command and status types
`default_nettype none

module ihn_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pt_valid,
	output logic               pt_ready,
	output logic               dist_valid,
	input  wire logic          dist_ready,
	input  wire ihn_pkg::sts_t sts,
	output ihn_pkg::cmd_t      cmd
);

	ihn_pkg::state_t state_q;
	ihn_pkg::state_t state_nxt;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || dist_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ihn_pkg::ST_IDLE: begin
				if (pt_valid) state_nxt = ihn_pkg::ST_INIT;
			end
			ihn_pkg::ST_INIT: begin
				state_nxt = sts.axis ? ihn_pkg::ST_FINISH : ihn_pkg::ST_SQ_DX;
			end
			ihn_pkg::ST_SQ_DX:  state_nxt = ihn_pkg::ST_SQ_SUM;
			ihn_pkg::ST_SQ_SUM: state_nxt = ihn_pkg::ST_CHECK;
			ihn_pkg::ST_CHECK: begin
				state_nxt = sts.iter_max ? ihn_pkg::ST_FINISH : ihn_pkg::ST_DIV_WAIT;
			end
			ihn_pkg::ST_DIV_WAIT: begin
				if (sts.div_done) begin
					state_nxt = sts.quo_zero ? ihn_pkg::ST_FINISH : ihn_pkg::ST_MUL_D;
				end
			end
			ihn_pkg::ST_MUL_D: state_nxt = ihn_pkg::ST_CHECK;
			ihn_pkg::ST_FINISH: begin
				if (slot_free) state_nxt = ihn_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = ihn_pkg::MUL_D;
		pt_ready    = 1'b0;
		unique case (state_q)
			ihn_pkg::ST_IDLE: begin
				pt_ready = 1'b1;
				cmd.load = pt_valid;
			end
			ihn_pkg::ST_INIT: begin
				cmd.init    = 1'b1;
				cmd.prod_en = 1'b1;
				cmd.mul_sel = ihn_pkg::MUL_DY;
			end
			ihn_pkg::ST_SQ_DX: begin
				cmd.tgt_copy = 1'b1;
				cmd.prod_en  = 1'b1;
				cmd.mul_sel  = ihn_pkg::MUL_DX;
			end
			ihn_pkg::ST_SQ_SUM: begin
				cmd.tgt_add = 1'b1;
				cmd.prod_en = 1'b1;
			end
			ihn_pkg::ST_CHECK: begin
				cmd.div_start = !sts.iter_max;
			end
			ihn_pkg::ST_DIV_WAIT: begin
				cmd.step = sts.div_done && !sts.quo_zero;
			end
			ihn_pkg::ST_MUL_D: begin
				cmd.prod_en = 1'b1;
			end
			ihn_pkg::ST_FINISH: begin
				cmd.emit = slot_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ihn_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (dist_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign dist_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- src/integer_hypot_newton_core.sv -----
// top level of the integer hypot newton core: controller plus datapath
// depends on ihn_pkg, ihn_ctrl, ihn_dp (with ihn_div) and the macros header
//
//   channel   handshake               payload
//   -------   ---------------------   ----------------------------------------------
//   point     pt_valid / pt_ready     first_row, first_col, second_row, second_col
//   distance  dist_valid / dist_ready dist_value
//
// one point pair is worked on at a time; pt_ready is high only while the controller idles
// same point or axis-aligned pair: init goes straight to finish, which registers the result once the output is free
// otherwise the squares are summed, then check / divide / correct repeats until a division gives a zero
//   correction or MAX_ITER corrections have been applied; the divider is bit-serial
// the output register holds a finished result, so a new transaction is taken while it waits
// arst_n clears the state machine and the output valid; payload registers are not reset
`default_nettype none

`include "integer_hypot_newton_core_macros.svh"

module integer_hypot_newton_core #(
	parameter int COORD_WIDTH = ihn_pkg::COORD_WIDTH_DEF,
	parameter int MAX_ITER    = ihn_pkg::MAX_ITER_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   pt_valid,
	output logic                        pt_ready,
	input  wire logic [COORD_WIDTH-1:0] first_row,
	input  wire logic [COORD_WIDTH-1:0] first_col,
	input  wire logic [COORD_WIDTH-1:0] second_row,
	input  wire logic [COORD_WIDTH-1:0] second_col,
	output logic                        dist_valid,
	input  wire logic                   dist_ready,
	output logic [ihn_pkg::DIST_WIDTH-1:0] dist_value
);

	// command and status between the controller and the datapath
	ihn_pkg::cmd_t cmd;
	ihn_pkg::sts_t sts;

	// sequencer: idle, init, squares (skipped for axis-aligned pairs), then check / divide / correct until done or capped
	ihn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_valid  (pt_valid),
		.pt_ready  (pt_ready),
		.dist_valid(dist_valid),
		.dist_ready(dist_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic: abs differences, shared squarer, serial divider, saturating output
	ihn_dp #(
		.COORD_WIDTH(COORD_WIDTH),
		.MAX_ITER   (MAX_ITER)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.first_row (first_row),
		.first_col (first_col),
		.second_row(second_row),
		.second_col(second_col),
		.dist_value(dist_value)
	);

	// a result is only written into a free (or draining) output register
	`IHN_ASSERT_SAME(a_emit_slot_free, cmd.emit, !dist_valid || dist_ready, "emit over a held result")
	// no division is started once the correction cap is reached
	`IHN_ASSERT_SAME(a_div_below_cap, cmd.div_start, !sts.iter_max, "division started at cap")
	// a correction is applied only for a finished, nonzero quotient
	`IHN_ASSERT_SAME(a_step_nonzero, cmd.step, sts.div_done && !sts.quo_zero, "bad correction step")
	// an accepted transaction always goes through the init step first
	`IHN_ASSERT_NEXT(a_accept_then_init, pt_valid && pt_ready, cmd.init && !cmd.emit, "no init after accept")

endmodule

`default_nettype wire

// ----- bench/integer_hypot_newton_core_test.sv -----
// self-checking testbench for integer_hypot_newton_core: directed table, then random point pairs
// needs ihn_pkg and the core rtl; each distance is checked against a hand-typed value or an in-bench newton predictor
`timescale 1ns / 1ps

module integer_hypot_newton_core_test;

	localparam int COORD_W        = ihn_pkg::COORD_WIDTH_DEF;
	localparam int ITER_CAP       = ihn_pkg::MAX_ITER_DEF;
	localparam int DIST_W         = ihn_pkg::DIST_WIDTH;
	localparam int RANDOM_PAIRS   = 1280;
	localparam int DIRECTED_ROWS  = 20;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_AT        = 300;
	localparam int HOLD_CYCLES    = 400;
	localparam int QUIET_FROM     = 700;
	localparam int QUIET_TO       = 900;
	localparam int DRAIN_CYCLES   = 20;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [DIST_W-1:0]  dist_t;

	// one point pair; known marks rows whose distance is typed in by hand
	typedef struct packed {
		coord_t first_row;
		coord_t first_col;
		coord_t second_row;
		coord_t second_col;
		logic   known;
		dist_t  known_dist;
	} pair_t;

	logic   clk;
	logic   arst_n;
	logic   pt_valid;
	logic   pt_ready;
	coord_t first_row;
	coord_t first_col;
	coord_t second_row;
	coord_t second_col;
	logic   dist_valid;
	logic   dist_ready;
	dist_t  dist_value;

	// travels with the payload so the monitor knows which expectation to use
	logic   pt_known;
	dist_t  pt_known_dist;

	dist_t  dist_expected [$];
	int     dist_count   = 0;
	int     errors       = 0;
	int     idle_cycles  = 0;
	bit     hold_done    = 0;

	pair_t directed_pairs [0:DIRECTED_ROWS-1] = '{
		// same point: zero distance
		'{10'd0,    10'd0,    10'd0,    10'd0,    1'b1, 11'd0},
		'{10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1, 11'd0},
		'{10'd512,  10'd341,  10'd512,  10'd341,  1'b1, 11'd0},
		// axis-aligned: the nonzero difference, both orders
		'{10'd0,    10'd0,    10'd1023, 10'd0,    1'b1, 11'd1023},
		'{10'd1023, 10'd5,    10'd0,    10'd5,    1'b1, 11'd1023},
		'{10'd0,    10'd0,    10'd0,    10'd1023, 1'b1, 11'd1023},
		'{10'd7,    10'd1023, 10'd7,    10'd0,    1'b1, 11'd1023},
		'{10'd600,  10'd600,  10'd601,  10'd600,  1'b1, 11'd1},
		'{10'd0,    10'd1,    10'd0,    10'd0,    1'b1, 11'd1},
		// exact triangle
		'{10'd0,    10'd0,    10'd3,    10'd4,    1'b1, 11'd5},
		// the rest go through the predictor
		'{10'd0,    10'd0,    10'd1,    10'd1,    1'b0, 11'd0},
		'{10'd12,   10'd13,   10'd7,    10'd1,    1'b0, 11'd0},
		'{10'd0,    10'd0,    10'd1023, 10'd1023, 1'b0, 11'd0},
		'{10'd1023, 10'd0,    10'd0,    10'd1023, 1'b0, 11'd0},
		'{10'd0,    10'd0,    10'd1023, 10'd1,    1'b0, 11'd0},
		'{10'd0,    10'd0,    10'd1,    10'd1023, 1'b0, 11'd0},
		'{10'd1023, 10'd1023, 10'd1,    10'd0,    1'b0, 11'd0},
		'{10'h2AA,  10'h155,  10'h155,  10'h2AA,  1'b0, 11'd0},
		'{10'h155,  10'h2AA,  10'h2AA,  10'h155,  1'b0, 11'd0},
		'{10'd0,    10'd0,    10'd2,    10'd3,    1'b0, 11'd0}
	};

	integer_hypot_newton_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pt_valid   (pt_valid),
		.pt_ready   (pt_ready),
		.first_row  (first_row),
		.first_col  (first_col),
		.second_row (second_row),
		.second_col (second_col),
		.dist_valid (dist_valid),
		.dist_ready (dist_ready),
		.dist_value (dist_value)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// newton iteration from max + min/2, corrections truncated toward zero, capped
	function automatic dist_t hypot_estimate(input coord_t r0, input coord_t c0,
			input coord_t r1, input coord_t c1);
		longint dy;
		longint dx;
		longint sum_sq;
		longint d;
		longint corr;
		bit     settled;
		dy = (r0 > r1) ? longint'(r0) - longint'(r1) : longint'(r1) - longint'(r0);
		dx = (c0 > c1) ? longint'(c0) - longint'(c1) : longint'(c1) - longint'(c0);
		d = (dy > dx) ? dy + (dx >>> 1) : dx + (dy >>> 1);
		if (dy != 0 && dx != 0) begin
			sum_sq = dy * dy + dx * dx;
			settled = 0;
			for (int i = 0; i < ITER_CAP; i++) begin
				if (!settled && d > 0) begin
					corr = (sum_sq - d * d) / (2 * d);
					if (corr == 0)
						settled = 1;
					else
						d = d + corr;
				end
			end
		end
		if (d < 0)
			d = 0;
		if (d > ihn_pkg::DIST_MAX)
			d = ihn_pkg::DIST_MAX;
		return d[DIST_W-1:0];
	endfunction

	// half uniform pairs, plus same points, axis lines, near neighbours, rows differing by at most 3, and corners
	function automatic pair_t random_pair();
		pair_t p;
		int    pick;
		p.first_row  = coord_t'($urandom);
		p.first_col  = coord_t'($urandom);
		p.second_row = coord_t'($urandom);
		p.second_col = coord_t'($urandom);
		p.known      = 1'b0;
		p.known_dist = '0;
		pick = $urandom_range(99);
		if (pick < 50) begin
		end else if (pick < 58) begin
			p.second_row = p.first_row;
			p.second_col = p.first_col;
		end else if (pick < 70) begin
			if ($urandom_range(1))
				p.second_row = p.first_row;
			else
				p.second_col = p.first_col;
		end else if (pick < 85) begin
			p.second_row = p.first_row + coord_t'($urandom_range(15));
			p.second_col = p.first_col - coord_t'($urandom_range(15));
		end else if (pick < 95) begin
			p.second_row = p.first_row ^ coord_t'($urandom_range(3));
		end else begin
			p.first_row  = $urandom_range(1) ? '1 : '0;
			p.first_col  = $urandom_range(1) ? '1 : '0;
			p.second_row = $urandom_range(1) ? '1 : '0;
			p.second_col = $urandom_range(1) ? '1 : '0;
		end
		return p;
	endfunction

	// raise valid with the pair and hold it until the core takes the transaction
	task automatic offer_pair(input pair_t p);
		pt_valid      <= 1'b1;
		first_row     <= p.first_row;
		first_col     <= p.first_col;
		second_row    <= p.second_row;
		second_col    <= p.second_col;
		pt_known      <= p.known;
		pt_known_dist <= p.known_dist;
		do
			@(posedge clk);
		while (pt_ready !== 1'b1);
	endtask

	// occasional sender gap, none inside the quiet stretch
	task automatic maybe_pause(input int item);
		if ((item < QUIET_FROM || item > QUIET_TO) && $urandom_range(99) < 6) begin
			pt_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// sender: reset, directed table, random pairs, then drain and report
	initial begin
		arst_n        = 1'b0;
		pt_valid      = 1'b0;
		first_row     = '0;
		first_col     = '0;
		second_row    = '0;
		second_col    = '0;
		pt_known      = 1'b0;
		pt_known_dist = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			offer_pair(directed_pairs[i]);
			maybe_pause(i);
		end
		for (int i = DIRECTED_ROWS; i < DIRECTED_ROWS + RANDOM_PAIRS; i++) begin
			offer_pair(random_pair());
			maybe_pause(i);
		end
		pt_valid <= 1'b0;
		// let the scoreboard queue the last prediction before looking at the queue
		@(posedge clk);
		while (dist_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// receiver: random stalls, one long hold-off so the core backs up into the sender
	initial begin
		dist_ready = 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (!hold_done && dist_count >= HOLD_AT) begin
				dist_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1;
			end
			if (dist_count >= QUIET_FROM && dist_count <= QUIET_TO)
				dist_ready <= 1'b1;
			else
				dist_ready <= ($urandom_range(99) >= 6);
			@(posedge clk);
		end
	end

	// scoreboard: check each distance transaction, then queue the prediction for a new pair
	always @(posedge clk) begin
		dist_t want;
		if (arst_n && dist_valid && dist_ready) begin
			if (dist_expected.size() == 0) begin
				$display("%0t: unexpected distance transaction, expected none, actual %0d",
					$time, dist_value);
				errors++;
			end else begin
				want = dist_expected.pop_front();
				if (dist_value !== want) begin
					$display("%0t: dist_value mismatch, expected %0d, actual %0d",
						$time, want, dist_value);
					errors++;
				end
			end
			dist_count++;
		end
		if (arst_n && pt_valid && pt_ready) begin
			if (pt_known)
				dist_expected.push_back(pt_known_dist);
			else
				dist_expected.push_back(hypot_estimate(first_row, first_col,
					second_row, second_col));
		end
	end

	// give up once nothing has moved on either channel for too long
	always @(posedge clk) begin
		if ((pt_valid && pt_ready) || (dist_valid && dist_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("Verification failed");
			$finish;
		end
	end

endmodule
